// ----- hw/rtl/lbt_pkg.sv -----
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared types and constants of the label table branch unit.
// ----------------------------------------------------------------------------
package lbt_pkg;

  localparam int TABLE_SLOTS_DEF    = 256;
  localparam int CODE_ADDR_BITS_DEF = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int LABEL_W            = 32;
  localparam int POS_W              = 16;

  typedef enum logic [1:0] {
    ACT_MARK    = 2'd0,
    ACT_GOTO    = 2'd1,
    ACT_IF_ZERO = 2'd2,
    ACT_IF_NEG  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // work for the back end: table insert, table lookup, or result already known
  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DONE   = 2'd2
  } op_e;

  typedef struct packed {
    action_e             action;
    logic signed [31:0]  label;
    logic [15:0]         code_pos;
    logic                stack_nonempty;
    logic signed [31:0]  stack_top;
  } cmd_t;

  typedef struct packed {
    status_e      status;
    logic         jump_taken;
    logic [15:0]  target_pc;
  } res_t;

  typedef struct packed {
    op_e                  op;
    status_e              status;
    logic [LABEL_W-1:0]   label;
    logic [POS_W-1:0]     code_pos;
  } job_t;

endpackage

// ----- hw/rtl/lbt_ram.sv -----
// ----------------------------------------------------------------------------
// lbt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/lbt_fifo.sv -----
// ----------------------------------------------------------------------------
// lbt_fifo
// Short job queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module lbt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/lbt_front.sv -----
// ----------------------------------------------------------------------------
// lbt_front
// Command intake: classifies each command and computes the home slot.
// ----------------------------------------------------------------------------
module lbt_front #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  lbt_pkg::cmd_t                     cmd_i,
  input  logic                              clearing_i,
  output logic                              push_o,
  output logic [$bits(lbt_pkg::job_t)+$clog2(TABLE_SLOTS)-1:0] push_data_o,
  input  logic                              full_i
);
  import lbt_pkg::*;

  localparam int  SB   = $clog2(TABLE_SLOTS);
  localparam bit  POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  // byte fold sum stays below 3 * 255 * 65535 + 65535 + 255 < 2**26
  localparam int  TW   = 26;
  localparam int  PW   = 2 * TW + 1;
  localparam int  SH   = TW + SB;
  localparam int  QW   = PW - SH;
  localparam logic [63:0]   NL  = 64'(TABLE_SLOTS);
  localparam logic [TW-1:0] C1  = TW'((64'd1 << 8) % NL);
  localparam logic [TW-1:0] C2  = TW'((64'd1 << 16) % NL);
  localparam logic [TW-1:0] C3  = TW'((64'd1 << 24) % NL);
  localparam logic [TW-1:0] CN  = TW'((NL - (64'd1 << 32) % NL) % NL);
  localparam logic [TW:0]   RCP = (TW + 1)'(((64'd1 << SH) + NL - 64'd1) / NL);
  localparam logic [TW-1:0] NT  = TW'(TABLE_SLOTS);

  logic           hold_q;
  logic           mod_busy_q;
  logic           step_q;
  job_t           job_q, job_d;
  logic [SB-1:0]  home_q;
  logic [TW-1:0]  fold_q, fold_d;
  logic [QW-1:0]  q_q, q_d;
  logic [PW-1:0]  prod;
  logic [TW-1:0]  rem_d;
  logic           accept;
  logic           cond;

  assign busy        = hold_q | clearing_i;
  assign accept      = start && !busy;
  assign push_o      = hold_q && !mod_busy_q && !full_i;
  assign push_data_o = {home_q, job_q};

  always_comb begin
    job_d          = '0;
    job_d.label    = cmd_i.label;
    job_d.code_pos = cmd_i.code_pos;
    job_d.status   = ST_OK;
    cond = (cmd_i.action == ACT_IF_ZERO) ? (cmd_i.stack_top == 32'sd0) : cmd_i.stack_top[31];
    case (cmd_i.action)
      ACT_MARK: job_d.op = OP_MARK;
      ACT_GOTO: job_d.op = OP_LOOKUP;
      ACT_IF_ZERO, ACT_IF_NEG: begin
        if (!cmd_i.stack_nonempty) begin
          job_d.op     = OP_DONE;
          job_d.status = ST_EMPTY;
        end else if (cond) begin
          job_d.op = OP_LOOKUP;
        end else begin
          job_d.op = OP_DONE;
        end
      end
      default: job_d.op = OP_DONE;
    endcase
  end

  // non power of two sizes: fold the label bytes with 2**(8k) mod N (negative
  // labels add N - 2**32 mod N), then take the remainder by reciprocal multiply
  always_comb begin
    fold_d = TW'(cmd_i.label[7:0]) + TW'(cmd_i.label[15:8]) * C1 +
             TW'(cmd_i.label[23:16]) * C2 + TW'(cmd_i.label[31:24]) * C3 +
             (cmd_i.label[31] ? CN : '0);
    prod   = PW'(fold_q) * PW'(RCP);
    q_d    = prod[PW-1:SH];
    rem_d  = fold_q - TW'(q_q) * NT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= 1'b0;
      mod_busy_q <= 1'b0;
    end else begin
      if (accept) begin
        hold_q     <= 1'b1;
        mod_busy_q <= !POW2 && (job_d.op != OP_DONE);
      end else begin
        if (push_o) begin
          hold_q <= 1'b0;
        end
        if (mod_busy_q && step_q) begin
          mod_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q  <= job_d;
      home_q <= cmd_i.label[SB-1:0];
      fold_q <= fold_d;
      step_q <= 1'b0;
    end else if (mod_busy_q) begin
      step_q <= 1'b1;
      if (!step_q) begin
        q_q <= q_d;
      end else begin
        home_q <= rem_d[SB-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/lbt_back.sv -----
// ----------------------------------------------------------------------------
// lbt_back
// Table engine: clears the slot RAM, then runs linear probe chains.
// ----------------------------------------------------------------------------
module lbt_back #(
  parameter int TABLE_SLOTS    = 256,
  parameter int CODE_ADDR_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$bits(lbt_pkg::job_t)+$clog2(TABLE_SLOTS)-1:0] head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              res_valid_o,
  output lbt_pkg::res_t                     res_o
);
  import lbt_pkg::*;

  localparam int SB    = $clog2(TABLE_SLOTS);
  localparam int VB    = $clog2(TABLE_SLOTS + 1);
  localparam int ENT_W = 1 + LABEL_W + CODE_ADDR_BITS;
  localparam logic [SB-1:0] LAST = SB'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK
  } state_e;

  state_e                    state_q;
  job_t                      job_q, head_job;
  logic [SB-1:0]             head_home;
  logic [SB-1:0]             cur_q, clr_q, next_idx;
  logic [VB-1:0]             visits_q;
  logic                      res_valid_q;
  res_t                      res_q, fin_res;
  logic                      fin, advance;
  logic                      rd_en, wr_en;
  logic [SB-1:0]             rd_addr, wr_addr;
  logic [ENT_W-1:0]          wr_data, rd_data;
  logic                      ent_valid, match, last_probe;
  logic [CODE_ADDR_BITS-1:0] ent_target;

  assign head_job  = head_i[$bits(job_t)-1:0];
  assign head_home = head_i[$bits(job_t) +: SB];

  assign ent_valid  = rd_data[ENT_W-1];
  assign ent_target = rd_data[CODE_ADDR_BITS-1:0];
  assign match      = ent_valid && (rd_data[CODE_ADDR_BITS +: LABEL_W] == job_q.label);
  assign last_probe = (visits_q == VB'(TABLE_SLOTS));
  assign next_idx   = (cur_q == LAST) ? '0 : cur_q + 1'b1;

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    fin     = 1'b0;
    advance = 1'b0;
    fin_res = '{status: ST_OK, jump_taken: 1'b0, target_pc: 16'd0};
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = {1'b1, job_q.label, CODE_ADDR_BITS'(job_q.code_pos)};
    rd_en   = 1'b0;
    rd_addr = head_home;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en = pop_o && (head_job.op != OP_DONE);
      end
      S_CHECK: begin
        if (job_q.op == OP_MARK) begin
          if (match) begin
            fin            = 1'b1;
            fin_res.status = ST_DUP;
          end else if (!ent_valid) begin
            fin   = 1'b1;
            wr_en = 1'b1;
          end else if (last_probe) begin
            fin            = 1'b1;
            fin_res.status = ST_FULL;
          end else begin
            advance = 1'b1;
          end
        end else begin
          if (!ent_valid) begin
            fin            = 1'b1;
            fin_res.status = ST_NOTFOUND;
          end else if (match) begin
            fin                = 1'b1;
            fin_res.jump_taken = 1'b1;
            fin_res.target_pc  = 16'(ent_target);
          end else if (last_probe) begin
            fin            = 1'b1;
            fin_res.status = ST_NOTFOUND;
          end else begin
            advance = 1'b1;
          end
        end
        rd_en   = advance;
        rd_addr = next_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            if (head_job.op == OP_DONE) begin
              res_valid_q <= 1'b1;
              res_q <= '{status: head_job.status, jump_taken: 1'b0, target_pc: 16'd0};
            end else begin
              state_q <= S_CHECK;
            end
            job_q    <= head_job;
            cur_q    <= head_home;
            visits_q <= VB'(1);
          end
        end
        S_CHECK: begin
          if (fin) begin
            res_valid_q <= 1'b1;
            res_q       <= fin_res;
            state_q     <= S_IDLE;
          end else begin
            cur_q    <= next_idx;
            visits_q <= visits_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  lbt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

// ----- hw/rtl/label_table_branch_unit.sv -----
// ----------------------------------------------------------------------------
// label_table_branch_unit
// Label table and branch resolution for a stack-machine interpreter.
// ----------------------------------------------------------------------------
// Usage:
//   Commands come in on cmd_i and transfer when start is high and busy is
//   low. Each command yields exactly one result on res_o, shown for one
//   cycle with res_valid_o; results come out in command order and the
//   receiver cannot stall them.
//   A command is held in the intake stage (when the table size is not a
//   power of two, the stage also computes the home-slot remainder for
//   commands that need the table), waits in a two-entry queue, then the
//   table engine dequeues it, reading its home slot over the registered
//   RAM read port, and checks the probed slots in turn. Commands resolved
//   without the table (empty stack, false condition) are answered when
//   dequeued. The intake takes no new command until the held one has
//   entered the queue, which waits while the queue is full, and the probe
//   engine sets the sustained rate.
//   After reset the engine clears every slot, one per cycle; busy stays
//   high until the clear is done.
// ----------------------------------------------------------------------------
module label_table_branch_unit #(
  parameter int TABLE_SLOTS    = lbt_pkg::TABLE_SLOTS_DEF,
  parameter int CODE_ADDR_BITS = lbt_pkg::CODE_ADDR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lbt_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output lbt_pkg::res_t res_o
);
  import lbt_pkg::*;

  localparam int Q_W = $bits(job_t) + $clog2(TABLE_SLOTS);

  logic           push, pop, full, empty, clearing;
  logic [Q_W-1:0] push_data, head;

  lbt_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .clearing_i (clearing),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  lbt_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  lbt_back #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .CODE_ADDR_BITS(CODE_ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // nothing can be in flight while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !res_valid_o && empty && !pop)
    else $error("result or queued job during table clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy)
    else $error("command intake open during table clear");

  // an accepted command holds the intake busy in the cycle after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("intake not held after command transfer");

endmodule

// ----- dv/label_table_branch_unit_test.sv -----
// ----------------------------------------------------------------------------
// label_table_branch_unit_test
// Self-checking bench for the label table branch unit. A queue of commands
// feeds a clocked driver. The driver resolves each transfer against a
// shadow label table, and the monitor checks every result against those
// predictions in order. The run covers directed corner cases, random
// label traffic under several sender gap profiles, and a filled table.
// ----------------------------------------------------------------------------
module label_table_branch_unit_test;
  import lbt_pkg::*;

  localparam int SLOTS       = TABLE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct {
    cmd_t        cmd;
    int unsigned gap;    // idle cycles after this command transfers
    bit          drain;  // hold this command until nothing is outstanding
  } cmd_item_t;

  typedef struct {
    res_t    res;
    longint  stamp;
  } branch_exp_t;

  logic  clk_i;
  logic  rst_ni = 1'b0;
  logic  start_s = 1'b0;
  cmd_t  cmd_s = '0;
  logic  busy_s;
  logic  res_valid;
  res_t  res;

  cmd_item_t   cmd_q[$];
  branch_exp_t branch_res_q[$];
  branch_exp_t mon_want;

  // shadow of the label table
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_label [SLOTS];
  logic [15:0] tbl_pc    [SLOTS];

  longint      cycle = 0;
  int          n_xfer = 0;
  int          n_checked = 0;
  int          n_items = 0;
  int          n_errors = 0;
  int unsigned hold_left = 0;

  // generator side
  int unsigned idle_pct = 0;
  bit          drain_next = 1'b0;
  logic [31:0] label_pool[$];
  bit          marked_set[int];

  label_table_branch_unit #(
    .TABLE_SLOTS   (SLOTS),
    .CODE_ADDR_BITS(CODE_ADDR_BITS_DEF)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start_s),
    .busy       (busy_s),
    .cmd_i      (cmd_s),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int home_slot(logic [31:0] lab);
    int h;
    h = int'(lab) % SLOTS;
    if (h < 0) h += SLOTS;
    return h;
  endfunction

  function automatic res_t lookup_label(logic [31:0] lab);
    res_t r;
    int   s;
    r = '0;
    r.status = ST_NOTFOUND;
    s = home_slot(lab);
    for (int k = 0; k < SLOTS; k++) begin
      if (!tbl_valid[s]) break;  // slots never free up, so a hole ends the chain
      if (tbl_label[s] == lab) begin
        r.status     = ST_OK;
        r.jump_taken = 1'b1;
        r.target_pc  = tbl_pc[s];
        break;
      end
      s = (s + 1) % SLOTS;
    end
    return r;
  endfunction

  function automatic res_t resolve_branch(cmd_t c);
    res_t r;
    int   s;
    bit   cond;
    r = '0;
    r.status = ST_OK;
    case (c.action)
      ACT_MARK: begin
        r.status = ST_FULL;
        s = home_slot(c.label);
        for (int k = 0; k < SLOTS; k++) begin
          if (tbl_valid[s] && tbl_label[s] == c.label) begin
            r.status = ST_DUP;
            break;
          end
          if (!tbl_valid[s]) begin
            tbl_valid[s] = 1'b1;
            tbl_label[s] = c.label;
            tbl_pc[s]    = c.code_pos;
            r.status     = ST_OK;
            break;
          end
          s = (s + 1) % SLOTS;
        end
      end
      ACT_GOTO: r = lookup_label(c.label);
      default: begin
        if (!c.stack_nonempty) begin
          r.status = ST_EMPTY;
        end else begin
          cond = (c.action == ACT_IF_ZERO) ? (c.stack_top == 0) : (c.stack_top < 0);
          if (cond) r = lookup_label(c.label);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH @%0d: %s", cycle, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic add_cmd(action_e a, logic [31:0] lab, logic [15:0] pos, bit ne,
                         logic [31:0] top);
    cmd_item_t it;
    it.cmd.action         = a;
    it.cmd.label          = lab;
    it.cmd.code_pos       = pos;
    it.cmd.stack_nonempty = ne;
    it.cmd.stack_top      = top;
    it.gap   = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    it.drain = drain_next;
    drain_next = 1'b0;
    if (a == ACT_MARK && !marked_set.exists(int'(lab))) begin
      marked_set[int'(lab)] = 1'b1;
      label_pool.push_back(lab);
    end
    cmd_q.push_back(it);
  endtask

  function automatic logic [31:0] fresh_label();
    logic [31:0] lab;
    case ($urandom_range(0, 3))
      0: lab = $urandom;
      1: lab = $urandom_range(0, 1023);
      2: begin
        // pile up near the top slots so chains wrap to slot 0
        lab = $urandom;
        lab[7:0] = 8'hf0 + 8'($urandom_range(0, 15));
      end
      default: lab = -$urandom_range(1, 1000);
    endcase
    return lab;
  endfunction

  function automatic logic [31:0] known_or_fresh(int unsigned pct_known);
    if (label_pool.size() != 0 && $urandom_range(0, 99) < pct_known)
      return label_pool[$urandom_range(0, label_pool.size() - 1)];
    return fresh_label();
  endfunction

  function automatic logic [31:0] pick_top();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      2: return -$urandom_range(1, 100);
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  task automatic add_random();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      add_cmd(ACT_MARK, known_or_fresh(25), 16'($urandom), 1'($urandom), $urandom);
    end else if (roll < 70) begin
      add_cmd(ACT_GOTO, known_or_fresh(60), 16'($urandom), 1'($urandom), $urandom);
    end else begin
      add_cmd((roll < 85) ? ACT_IF_ZERO : ACT_IF_NEG, known_or_fresh(60), 16'($urandom),
              $urandom_range(0, 99) < 85, pick_top());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one command at a time, transfer when start is high and busy is low
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_s && busy_s === 1'b0) begin
        branch_res_q.push_back('{res: resolve_branch(cmd_s), stamp: cycle});
        n_xfer++;
      end
      if (start_s && busy_s !== 1'b0) begin
        // keep the command up until it transfers
      end else if (hold_left != 0) begin
        hold_left--;
        start_s <= 1'b0;
      end else if (cmd_q.size() == 0 || (cmd_q[0].drain && n_checked != n_xfer)) begin
        start_s <= 1'b0;
      end else begin
        cmd_s     <= cmd_q[0].cmd;
        hold_left  = cmd_q[0].gap;
        start_s   <= 1'b1;
        void'(cmd_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results come in command order, one strobe each
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid === 1'b1) begin
      // an entry stamped this cycle belongs to a transfer at this very edge
      if (branch_res_q.size() == 0 || branch_res_q[0].stamp == cycle) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d jump %0b pc %h",
                                  res.status, res.jump_taken, res.target_pc));
      end else begin
        mon_want = branch_res_q.pop_front();
        if (res.status !== mon_want.res.status)
          report_mismatch($sformatf("status got %0d want %0d", res.status,
                                    mon_want.res.status));
        if (res.jump_taken !== mon_want.res.jump_taken)
          report_mismatch($sformatf("jump_taken got %b want %b", res.jump_taken,
                                    mon_want.res.jump_taken));
        if (res.target_pc !== mon_want.res.target_pc)
          report_mismatch($sformatf("target_pc got %h want %h", res.target_pc,
                                    mon_want.res.target_pc));
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cycle, n_checked, n_items);
      $display("label_table_branch_unit_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // directed: collisions on slot 0, wrap from the last slot, all branch kinds
    idle_pct = 0;
    add_cmd(ACT_GOTO,    32'd0,          16'h0000, 1'b1, 32'd0);        // empty table
    add_cmd(ACT_MARK,    32'd0,          16'h0000, 1'b0, 32'd0);
    add_cmd(ACT_MARK,    32'd0,          16'hffff, 1'b1, 32'hffffffff); // duplicate
    add_cmd(ACT_MARK,    32'h7fffffff,   16'hffff, 1'b0, 32'd0);        // slot 255
    add_cmd(ACT_MARK,    32'h80000000,   16'h1234, 1'b0, 32'd0);        // home 0, probes
    add_cmd(ACT_MARK,    32'hffffffff,   16'haaaa, 1'b0, 32'd0);        // wraps past 255
    add_cmd(ACT_GOTO,    32'hffffffff,   16'h0000, 1'b0, 32'd0);
    add_cmd(ACT_GOTO,    32'h80000000,   16'h0000, 1'b0, 32'd0);
    add_cmd(ACT_GOTO,    32'd256,        16'h0000, 1'b0, 32'd0);        // miss at hole
    add_cmd(ACT_IF_ZERO, 32'd0,          16'h0000, 1'b0, 32'd0);        // empty stack
    add_cmd(ACT_IF_ZERO, 32'd0,          16'h0000, 1'b1, 32'd0);
    add_cmd(ACT_IF_ZERO, 32'd0,          16'h0000, 1'b1, 32'd1);
    add_cmd(ACT_IF_ZERO, 32'd0,          16'h0000, 1'b1, 32'hffffffff);
    add_cmd(ACT_IF_NEG,  32'h7fffffff,   16'h0000, 1'b1, 32'h80000000);
    add_cmd(ACT_IF_NEG,  32'h7fffffff,   16'h0000, 1'b1, 32'd0);
    add_cmd(ACT_IF_NEG,  32'h7fffffff,   16'h0000, 1'b1, 32'h7fffffff);
    add_cmd(ACT_IF_NEG,  32'h7fffffff,   16'h0000, 1'b0, 32'hffffffff); // empty stack
    add_cmd(ACT_IF_NEG,  32'd5,          16'h0000, 1'b1, 32'hffffffff); // unknown
    add_cmd(ACT_IF_ZERO, 32'd5,          16'h0000, 1'b1, 32'd0);        // unknown
    add_cmd(ACT_GOTO,    32'h7fffffff,   16'h0000, 1'b0, 32'd0);
    add_cmd(ACT_MARK,    32'hffffff00,   16'h5555, 1'b1, 32'd0);        // -256, home 0
    add_cmd(ACT_GOTO,    32'hffffff00,   16'h0000, 1'b0, 32'd0);

    // random traffic: no gaps, sender gaps, no gaps, light sender gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct   = (ph == 1) ? 45 : (ph == 3) ? 28 : 0;
      drain_next = 1'b1;
      repeat (185) add_random();
    end

    // fill the table, then hit it full: failed insert and whole-table scans
    while (marked_set.num() < SLOTS)
      add_cmd(ACT_MARK, fresh_label(), 16'($urandom), 1'b0, $urandom);
    drain_next = 1'b1;
    repeat (4) add_cmd(ACT_MARK, fresh_label(), 16'($urandom), 1'b0, $urandom);
    repeat (4) add_cmd(ACT_GOTO, fresh_label(), 16'($urandom), 1'b0, $urandom);
    repeat (20) add_random();
    n_items = cmd_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_checked != n_items) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (branch_res_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", branch_res_q.size()));

    if (n_errors == 0) begin
      $display("label_table_branch_unit_test: clean");
    end else begin
      $display("label_table_branch_unit_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lbt_pkg.sv
hw/rtl/lbt_ram.sv
hw/rtl/lbt_fifo.sv
hw/rtl/lbt_front.sv
hw/rtl/lbt_back.sv
hw/rtl/label_table_branch_unit.sv
dv/label_table_branch_unit_test.sv
